/* rtl/shsp_pkg.sv */
// ----------------------------------------------------------------------------
// shsp_pkg
// Types, codes and constants of the half-step stepper positioner.
// ----------------------------------------------------------------------------
package shsp_pkg;

  localparam int PositionBitsDef = 16;
  localparam int StepsBits       = 17;
  localparam int TightEndReset   = 2500;
  localparam int RelaxEndReset   = -2500;

  localparam logic [StepsBits-1:0] StepsMax   = '1;
  localparam logic [15:0]          PeriodReset = 16'd1000;

  // request codes of an input word
  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_GOTO       = 3'd1,
    REQ_MOVE       = 3'd2,
    REQ_SEEK_TIGHT = 3'd3,
    REQ_SEEK_RELAX = 3'd4,
    REQ_GOTO_TIGHT = 3'd5,
    REQ_GOTO_RELAX = 3'd6
  } req_e;

  // spare request code, handled as a plain tick
  localparam logic [2:0] ReqReserved = 3'd7;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_MOVE       = 2'd1,
    MODE_SEEK_TIGHT = 2'd2,
    MODE_SEEK_RELAX = 2'd3
  } mode_e;

  // configuration register indexes
  localparam logic CfgStepPeriod = 1'b0;
  localparam logic CfgDirReverse = 1'b1;

  // half-step coil patterns, bit 0 is the first coil
  localparam logic [3:0] CoilTable [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] move_value;
    logic               limit_switch;
  } in_t;

  typedef struct packed {
    logic [3:0]         coil_pattern;
    logic signed [15:0] position;
    logic               busy_res;
    logic               rejected;
    logic signed [15:0] tight_end;
    logic signed [15:0] relax_end;
  } out_t;

  // saturate a reset value into a signed range of the given width
  function automatic longint clamp_pos(longint value, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (value > hi) return hi;
    if (value < lo) return lo;
    return value;
  endfunction

endpackage

/* rtl/stepper_half_step_positioner.sv */
// Result: a word accepted at a clock edge has its result loaded into the output
//   register at that same edge.
// Throughput: one word per cycle while the result is taken; the command, the
//   limit check and the step are all done by the logic between the state and the result register.
// Reset: clears motion and position, coils off, step period 1000, ends at
//   +/-2500 saturated to the position width.
// ----------------------------------------------------------------------------
// stepper_half_step_positioner
// Half-step stepper sequencer with go-to, relative move and limit seeking.
// ----------------------------------------------------------------------------
module stepper_half_step_positioner #(
  parameter int POSITION_BITS = shsp_pkg::PositionBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  shsp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output shsp_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_addr_i,
  input  logic [15:0]    cfg_data_i
);
  import shsp_pkg::*;

  localparam int P  = POSITION_BITS;
  localparam int DW = ((P > 16) ? P : 16) + 1;

  localparam logic [P-1:0] PosMax   = {1'b0, {(P-1){1'b1}}};
  localparam logic [P-1:0] PosMin   = {1'b1, {(P-1){1'b0}}};
  localparam logic [P-1:0] TightRst = P'(clamp_pos(longint'(TightEndReset), P));
  localparam logic [P-1:0] RelaxRst = P'(clamp_pos(longint'(RelaxEndReset), P));

  // sign-extend or cut a position to the 16-bit result field
  function automatic logic [15:0] to_field(logic [P-1:0] v);
    logic [32:0] ext;
    ext = {{(33-P){v[P-1]}}, v};
    return ext[15:0];
  endfunction

  function automatic logic [DW-1:0] to_wide(logic [P-1:0] v);
    return {{(DW-P){v[P-1]}}, v};
  endfunction

  logic [15:0]          period_q;
  logic                 dir_rev_q;
  mode_e                mode_q, mode_d;
  logic [P-1:0]         pos_q, pos_d;
  logic [P-1:0]         tight_q, tight_d;
  logic [P-1:0]         relax_q, relax_d;
  logic [StepsBits-1:0] steps_q, steps_d;
  logic                 neg_q, neg_d;
  logic [15:0]          cnt_q, cnt_d;
  logic [2:0]           phase_q, phase_d;
  logic [3:0]           coil_q, coil_d;
  logic                 out_valid_q;
  out_t                 out_q;

  logic                 in_fire;
  req_e                 req;
  logic                 is_cmd;
  logic                 rejected;
  logic [DW-1:0]        delta;
  logic [DW-1:0]        mag;
  logic [StepsBits-1:0] steps_sat;
  logic [DW-1:0]        mv_wide;
  logic                 step_neg;
  logic                 fwd;
  logic [StepsBits-1:0] steps_dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign req        = req_e'(in_data_i.req_type);
  assign is_cmd     = (in_data_i.req_type != REQ_TICK) &&
                      (in_data_i.req_type != ReqReserved);
  assign mv_wide    = {{(DW-16){in_data_i.move_value[15]}}, in_data_i.move_value};

  // move distance of a go-to or relative command
  always_comb begin
    case (req)
      REQ_GOTO:       delta = mv_wide - to_wide(pos_q);
      REQ_GOTO_TIGHT: delta = to_wide(tight_q) - to_wide(pos_q);
      REQ_GOTO_RELAX: delta = to_wide(relax_q) - to_wide(pos_q);
      default:        delta = mv_wide;
    endcase
  end

  assign mag       = delta[DW-1] ? (~delta + DW'(1)) : delta;
  assign steps_sat = (mag > DW'(StepsMax)) ? StepsMax : mag[StepsBits-1:0];

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    tight_d   = tight_q;
    relax_d   = relax_q;
    steps_d   = steps_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    coil_d    = coil_q;
    rejected  = 1'b0;
    step_neg  = 1'b0;
    fwd       = 1'b0;
    steps_dec = '0;

    if (is_cmd) begin
      if (mode_q != MODE_IDLE) begin
        rejected = 1'b1;
      end else begin
        cnt_d = '0;
        case (req)
          REQ_SEEK_TIGHT: mode_d = MODE_SEEK_TIGHT;
          REQ_SEEK_RELAX: mode_d = MODE_SEEK_RELAX;
          default: begin
            if (delta == '0) begin
              mode_d  = MODE_IDLE;
              steps_d = '0;
            end else begin
              neg_d   = delta[DW-1];
              steps_d = steps_sat;
              mode_d  = MODE_MOVE;
            end
          end
        endcase
      end
    end

    if (mode_d != MODE_IDLE) begin
      step_neg  = (mode_d == MODE_MOVE) ? neg_d : (mode_d == MODE_SEEK_RELAX);
      fwd       = !step_neg ^ dir_rev_q;
      steps_dec = steps_d - StepsBits'(1);
      if (mode_d != MODE_MOVE && !in_data_i.limit_switch) begin
        // switch pressed: record this end and stop
        if (mode_d == MODE_SEEK_TIGHT) tight_d = pos_q;
        else relax_d = pos_q;
        mode_d  = MODE_IDLE;
        steps_d = '0;
      end else if (cnt_d != '0) begin
        cnt_d = cnt_d - 16'd1;
      end else if (step_neg ? (pos_q == PosMin) : (pos_q == PosMax)) begin
        mode_d  = MODE_IDLE;
        steps_d = '0;
      end else begin
        pos_d   = step_neg ? (pos_q - P'(1)) : (pos_q + P'(1));
        phase_d = phase_q + (fwd ? 3'd1 : 3'd7);
        coil_d  = CoilTable[phase_d];
        cnt_d   = (period_q != '0) ? (period_q - 16'd1) : '0;
        if (mode_d == MODE_MOVE) begin
          steps_d = steps_dec;
          if (steps_dec == '0) mode_d = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PeriodReset;
      dir_rev_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgStepPeriod: period_q  <= cfg_data_i;
        CfgDirReverse: dir_rev_q <= cfg_data_i[0];
        default:       period_q  <= period_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      tight_q <= TightRst;
      relax_q <= RelaxRst;
      steps_q <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      phase_q <= '0;
      coil_q  <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      tight_q <= tight_d;
      relax_q <= relax_d;
      steps_q <= steps_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      coil_q  <= coil_d;
    end
  end

  // result register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.coil_pattern <= coil_d;
      out_q.position     <= to_field(pos_d);
      out_q.busy_res     <= (mode_d != MODE_IDLE);
      out_q.rejected     <= rejected;
      out_q.tight_end    <= to_field(tight_d);
      out_q.relax_end    <= to_field(relax_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_reject_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_cmd && mode_q != MODE_IDLE |=> out_q.rejected)
    else $error("command taken while busy was not rejected");

  a_one_step_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pos_q == $past(pos_q) || pos_q == $past(pos_q) + P'(1)
             || pos_q == $past(pos_q) - P'(1))
    else $error("position moved by more than one step");

  a_hold_without_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(pos_q) && $stable(mode_q) && $stable(phase_q))
    else $error("state changed with no word accepted");

  a_coil_half_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(coil_q) <= 2)
    else $error("more than two coils driven");

  a_idle_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> steps_q == '0)
    else $error("idle with steps left");
`endif

endmodule
